[hdl/attenv_pkg.sv]
// Types, constants and helper functions for the attitude envelope servo limiter.
`timescale 1ns / 1ps

package attenv_pkg;

   localparam int ANG_W      = 13;
   localparam int SERVO_W    = 12;
   localparam int MAG_W      = ANG_W;
   localparam int DIFF_W     = ANG_W + 1;
   localparam int SPAN_W     = SERVO_W + 1;
   localparam int PROD_W     = MAG_W + SERVO_W;
   localparam int VAL_W      = PROD_W + 2;
   localparam int DIV_STEPS  = 5;
   localparam int DIV_STAGES = (PROD_W + DIV_STEPS - 1) / DIV_STEPS;
   localparam int NUM_STG    = DIV_STAGES + 4;
   localparam int STG_S1     = 0;
   localparam int STG_S2     = 1;
   localparam int STG_S3     = 2;
   localparam int STG_DIV    = 3;
   localparam int STG_OUT    = NUM_STG - 1;
   localparam int NUM_REGS   = 8;
   localparam int REG_SEL_W  = $clog2(NUM_REGS);
   localparam int CSR_IDX_W  = REG_SEL_W + 1;

   localparam logic [SERVO_W-1:0] ELEV_LOW_US    = SERVO_W'(1000);
   localparam logic [SERVO_W-1:0] ELEV_CENTRE_US = SERVO_W'(1500);
   localparam logic [SERVO_W-1:0] ELEV_HIGH_US   = SERVO_W'(2000);
   localparam logic [SERVO_W-1:0] AIL_LOW_US     = SERVO_W'(1000);
   localparam logic [SERVO_W-1:0] AIL_CENTRE_US  = SERVO_W'(1500);
   localparam logic [SERVO_W-1:0] AIL_HIGH_US    = SERVO_W'(2000);

   localparam logic AXIS_ROLL = 1'b1;

   typedef logic signed [ANG_W-1:0] angle_type;

   typedef enum logic [REG_SEL_W-1:0] {
      REG_PITCH_UP_UNSAFE,
      REG_PITCH_UP_EXTREME,
      REG_PITCH_DOWN_UNSAFE,
      REG_PITCH_DOWN_EXTREME,
      REG_ROLL_RIGHT_UNSAFE,
      REG_ROLL_RIGHT_EXTREME,
      REG_ROLL_LEFT_UNSAFE,
      REG_ROLL_LEFT_EXTREME
   } reg_sel_type;

   localparam angle_type REG_RESET [NUM_REGS] = '{
      ANG_W'(-480), ANG_W'(-960), ANG_W'(480), ANG_W'(960),
      ANG_W'(-720), ANG_W'(-1440), ANG_W'(720), ANG_W'(1440)
   };

   typedef struct packed {
      logic               active;
      logic               want_less;
      logic [SERVO_W-1:0] mid;
      logic [SERVO_W-1:0] tgt;
      logic [SERVO_W-1:0] lo;
      logic [SERVO_W-1:0] hi;
      logic [SERVO_W-1:0] cur;
   } ctl_type;

   typedef struct packed {
      angle_type angle;
      angle_type unsafe_b;
      angle_type extreme_b;
      ctl_type   ctl;
   } s1_type;

   typedef struct packed {
      logic [MAG_W-1:0]   num_mag;
      logic [SERVO_W-1:0] span_mag;
      logic [MAG_W-1:0]   den_mag;
      logic               neg;
      logic               dz;
      ctl_type            ctl;
   } s2_type;

   typedef struct packed {
      logic [PROD_W-1:0] prod;
      logic [MAG_W-1:0]  den_mag;
      logic              neg;
      logic              dz;
      ctl_type           ctl;
   } s3_type;

   typedef struct packed {
      logic [MAG_W-1:0]  rem;
      logic [PROD_W-1:0] dq;
      logic [MAG_W-1:0]  den_mag;
      logic              neg;
      logic              dz;
      ctl_type           ctl;
   } div_type;

   typedef struct packed {
      logic [SERVO_W-1:0] limited;
      logic               ovr;
   } out_type;

   function automatic logic [MAG_W-1:0] mag_of(input angle_type a);
      logic signed [DIFF_W-1:0] ext;
      logic signed [DIFF_W-1:0] m;
      ext = DIFF_W'(a);
      m   = a[ANG_W-1] ? -ext : ext;
      return m[MAG_W-1:0];
   endfunction

   function automatic logic [MAG_W-1:0] abs_diff(input logic signed [DIFF_W-1:0] x);
      logic signed [DIFF_W-1:0] m;
      m = x[DIFF_W-1] ? -x : x;
      return m[MAG_W-1:0];
   endfunction

   function automatic logic [SERVO_W-1:0] abs_span(input logic signed [SPAN_W-1:0] x);
      logic signed [SPAN_W-1:0] m;
      m = x[SPAN_W-1] ? -x : x;
      return m[SERVO_W-1:0];
   endfunction

   function automatic div_type div_step(input div_type d);
      div_type          r;
      logic [MAG_W:0]   part;
      logic [MAG_W:0]   dvs;
      logic [MAG_W:0]   trial;
      logic             qbit;
      r     = d;
      part  = {d.rem, d.dq[PROD_W-1]};
      dvs   = {1'b0, d.den_mag};
      trial = part - dvs;
      qbit  = (part >= dvs);
      r.rem = qbit ? trial[MAG_W-1:0] : part[MAG_W-1:0];
      r.dq  = {d.dq[PROD_W-2:0], qbit};
      return r;
   endfunction

endpackage

[hdl/attitude_envelope_servo_limiter_core.sv]
// Top level of the attitude envelope servo limiter: selection, map, divider and clamp pipeline.
`timescale 1ns / 1ps

// One beat in, one beat out, in order. An item enters every cycle while the output
// side keeps up; the depth is set by the 25-step restoring divider, spread over five
// stages of five steps each. Empty stages close up under a stall, so a new beat is
// taken while a result waits. The eight threshold registers are written through the
// csr_ port (index 0..7 in list order, index 8 and above ignored); the user must
// write them only while no beat is in flight; the block itself does not enforce it.

module attitude_envelope_servo_limiter_core
   import attenv_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_command,
   input  logic signed [ANG_W-1:0] req_attitude_angle,
   input  logic [SERVO_W-1:0]     req_current_servo,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [SERVO_W-1:0]     rsp_limited_servo,
   output logic                   rsp_was_overridden,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [ANG_W-1:0]       csr_data
);

   angle_type            cfg_ff [NUM_REGS];
   angle_type            cfg_in [NUM_REGS];
   logic [NUM_STG-1:0]   vld_ff;
   logic [NUM_STG-1:0]   vld_in;
   logic [NUM_STG-1:0]   adv;
   s1_type               s1_ff;
   s1_type               s1_in;
   s2_type               s2_ff;
   s2_type               s2_in;
   s3_type               s3_ff;
   s3_type               s3_in;
   div_type              div_src [DIV_STAGES];
   div_type              div_ff  [DIV_STAGES];
   div_type              div_in  [DIV_STAGES];
   out_type              out_ff;
   out_type              out_in;

   // configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && (csr_index < CSR_IDX_W'(NUM_REGS))) begin
         cfg_in[csr_index[REG_SEL_W-1:0]] = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= REG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // stage valid bits and advance chain
   always_comb begin
      adv[STG_OUT] = !vld_ff[STG_OUT] || rsp_ready;
      for (int i = STG_OUT - 1; i >= 0; i--) begin
         adv[i] = !vld_ff[i] || adv[i+1];
      end
      vld_in[0] = adv[0] ? req_valid : vld_ff[0];
      for (int i = 1; i < NUM_STG; i++) begin
         vld_in[i] = adv[i] ? vld_ff[i-1] : vld_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_ready = adv[STG_S1];

   // stage 1: pick the side and its bounds
   always_comb begin
      angle_type u_lo;
      angle_type e_lo;
      angle_type u_hi;
      angle_type e_hi;
      logic      hit_lo;
      logic      hit_hi;
      if (req_command == AXIS_ROLL) begin
         u_lo = cfg_ff[REG_ROLL_RIGHT_UNSAFE];
         e_lo = cfg_ff[REG_ROLL_RIGHT_EXTREME];
         u_hi = cfg_ff[REG_ROLL_LEFT_UNSAFE];
         e_hi = cfg_ff[REG_ROLL_LEFT_EXTREME];
      end else begin
         u_lo = cfg_ff[REG_PITCH_UP_UNSAFE];
         e_lo = cfg_ff[REG_PITCH_UP_EXTREME];
         u_hi = cfg_ff[REG_PITCH_DOWN_UNSAFE];
         e_hi = cfg_ff[REG_PITCH_DOWN_EXTREME];
      end
      hit_lo = (req_attitude_angle <= u_lo);
      hit_hi = (req_attitude_angle >= u_hi);

      s1_in.angle          = req_attitude_angle;
      s1_in.unsafe_b       = hit_lo ? u_lo : u_hi;
      s1_in.extreme_b      = hit_lo ? e_lo : e_hi;
      s1_in.ctl.active     = hit_lo || hit_hi;
      s1_in.ctl.cur        = req_current_servo;
      if (req_command == AXIS_ROLL) begin
         s1_in.ctl.mid = AIL_CENTRE_US;
         if (hit_lo) begin
            s1_in.ctl.tgt       = AIL_HIGH_US;
            s1_in.ctl.lo        = AIL_CENTRE_US;
            s1_in.ctl.hi        = AIL_HIGH_US;
            s1_in.ctl.want_less = 1'b0;
         end else begin
            s1_in.ctl.tgt       = AIL_LOW_US;
            s1_in.ctl.lo        = AIL_LOW_US;
            s1_in.ctl.hi        = AIL_CENTRE_US;
            s1_in.ctl.want_less = 1'b1;
         end
      end else begin
         s1_in.ctl.mid = ELEV_CENTRE_US;
         if (hit_lo) begin
            s1_in.ctl.tgt       = ELEV_LOW_US;
            s1_in.ctl.lo        = ELEV_LOW_US;
            s1_in.ctl.hi        = ELEV_CENTRE_US;
            s1_in.ctl.want_less = 1'b1;
         end else begin
            s1_in.ctl.tgt       = ELEV_HIGH_US;
            s1_in.ctl.lo        = ELEV_CENTRE_US;
            s1_in.ctl.hi        = ELEV_HIGH_US;
            s1_in.ctl.want_less = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[STG_S1]) begin
         s1_ff <= s1_in;
      end
   end

   // stage 2: magnitudes and differences
   always_comb begin
      logic [MAG_W-1:0]          mag_a;
      logic [MAG_W-1:0]          mag_u;
      logic [MAG_W-1:0]          mag_e;
      logic signed [DIFF_W-1:0]  num;
      logic signed [DIFF_W-1:0]  den;
      logic signed [SPAN_W-1:0]  span;
      mag_a = mag_of(s1_ff.angle);
      mag_u = mag_of(s1_ff.unsafe_b);
      mag_e = mag_of(s1_ff.extreme_b);
      num   = $signed({1'b0, mag_a}) - $signed({1'b0, mag_u});
      den   = $signed({1'b0, mag_e}) - $signed({1'b0, mag_u});
      span  = $signed({1'b0, s1_ff.ctl.tgt}) - $signed({1'b0, s1_ff.ctl.mid});
      s2_in.num_mag  = abs_diff(num);
      s2_in.den_mag  = abs_diff(den);
      s2_in.span_mag = abs_span(span);
      s2_in.neg      = num[DIFF_W-1] ^ den[DIFF_W-1] ^ span[SPAN_W-1];
      s2_in.dz       = (den == '0);
      s2_in.ctl      = s1_ff.ctl;
   end

   always_ff @(posedge clock) begin
      if (adv[STG_S2]) begin
         s2_ff <= s2_in;
      end
   end

   // stage 3: product magnitude
   always_comb begin
      s3_in.prod    = PROD_W'(s2_ff.num_mag) * PROD_W'(s2_ff.span_mag);
      s3_in.den_mag = s2_ff.den_mag;
      s3_in.neg     = s2_ff.neg;
      s3_in.dz      = s2_ff.dz;
      s3_in.ctl     = s2_ff.ctl;
   end

   always_ff @(posedge clock) begin
      if (adv[STG_S3]) begin
         s3_ff <= s3_in;
      end
   end

   // divider stages
   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
      if (s == 0) begin : g_head
         assign div_src[s] = {MAG_W'(0), s3_ff.prod, s3_ff.den_mag, s3_ff.neg, s3_ff.dz,
                              s3_ff.ctl};
      end else begin : g_link
         assign div_src[s] = div_ff[s-1];
      end

      always_comb begin
         div_type w;
         w = div_src[s];
         for (int k = 0; k < DIV_STEPS; k++) begin
            if (s * DIV_STEPS + k < PROD_W) begin
               w = div_step(w);
            end
         end
         div_in[s] = w;
      end

      always_ff @(posedge clock) begin
         if (adv[STG_DIV+s]) begin
            div_ff[s] <= div_in[s];
         end
      end
   end

   // output stage: offset, clamp, compare
   always_comb begin
      div_type                  d;
      logic signed [VAL_W-1:0]  q;
      logic signed [VAL_W-1:0]  val;
      logic signed [VAL_W-1:0]  lo_s;
      logic signed [VAL_W-1:0]  hi_s;
      logic [SERVO_W-1:0]       cmd;
      logic                     take;
      d    = div_ff[DIV_STAGES-1];
      q    = $signed({2'b00, d.dq});
      lo_s = $signed({{(VAL_W-SERVO_W){1'b0}}, d.ctl.lo});
      hi_s = $signed({{(VAL_W-SERVO_W){1'b0}}, d.ctl.hi});
      if (d.dz) begin
         val = $signed({{(VAL_W-SERVO_W){1'b0}}, d.ctl.tgt});
      end else begin
         val = $signed({{(VAL_W-SERVO_W){1'b0}}, d.ctl.mid}) + (d.neg ? -q : q);
      end
      if (val < lo_s) begin
         cmd = d.ctl.lo;
      end else if (val > hi_s) begin
         cmd = d.ctl.hi;
      end else begin
         cmd = val[SERVO_W-1:0];
      end
      take = d.ctl.active && (d.ctl.want_less ? (cmd < d.ctl.cur) : (cmd > d.ctl.cur));
      out_in.limited = take ? cmd : d.ctl.cur;
      out_in.ovr     = take;
   end

   always_ff @(posedge clock) begin
      if (adv[STG_OUT]) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid          = vld_ff[STG_OUT];
   assign rsp_limited_servo  = out_ff.limited;
   assign rsp_was_overridden = out_ff.ovr;

   a_reset_empties : assert property (@(posedge clock)
      reset |=> (vld_ff == '0))
      else $error("pipeline not empty after reset");

   a_accept_fills : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> vld_ff[STG_S1])
      else $error("accepted beat missing from first stage");

   a_stall_holds : assert property (@(posedge clock) disable iff (reset)
      (vld_ff[STG_S3] && !adv[STG_S3]) |=> vld_ff[STG_S3])
      else $error("stalled beat dropped in product stage");

   a_rem_bound : assert property (@(posedge clock) disable iff (reset)
      (vld_ff[STG_OUT-1] && !div_ff[DIV_STAGES-1].dz)
         |-> (div_ff[DIV_STAGES-1].rem < div_ff[DIV_STAGES-1].den_mag))
      else $error("divider remainder not below divisor");

endmodule
